// ===== hdl/stg_pkg.sv =====
package stg_pkg;

  // Ring depth default and fixed field widths
  localparam int unsigned QUEUE_DEPTH = 4096;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned GUARD_W     = 20;
  localparam int unsigned QCNT_W      = 12;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_BYTE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_BYTE = 2'd2;

  // Configuration reset values
  localparam logic [GUARD_W-1:0] GUARD_TICKS_RST = 20'd75000;
  localparam logic [BYTE_W-1:0]  LEAD_BYTE_RST   = 8'hc5;
  localparam logic [BYTE_W-1:0]  FOLLOW_BYTE_RST = 8'h01;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef enum logic [1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_FOLLOW    = 2'd1,
    MODE_IDLE_WAIT = 2'd2,
    MODE_HOLD      = 2'd3
  } mode_e;

  typedef struct packed {
    logic [GUARD_W-1:0] guard_ticks;
    logic [BYTE_W-1:0]  lead_byte;
    logic [BYTE_W-1:0]  follow_byte;
  } cfg_t;

  typedef struct packed {
    logic              is_tick;
    logic [BYTE_W-1:0] push_byte;
    logic              uart_full;
    logic              uart_empty;
    logic              uart_busy;
  } item_t;

  typedef struct packed {
    logic              tx_valid;
    logic [BYTE_W-1:0] tx_byte;
    mode_e             gate_mode;
    logic [QCNT_W-1:0] queue_count;
    logic              push_dropped;
  } result_t;

endpackage

// ===== hdl/serial_tx_reset_guard_gate.sv =====
// Each result is pushed into the result queue in the same cycle that its item is accepted.
// The back stage takes one item per cycle while a result slot is free; it handles each
// push or tick against the ring memory, with the head and next bytes prefetched.
// Input and result queues are two beats deep, so either side may stall alone.
// Reset: queue empty, gate mode normal, guard counter zero, registers at defaults;
// the ring memory is not cleared and needs no clearing pass.
module serial_tx_reset_guard_gate import stg_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  cmd_i,
  input  logic [BYTE_W-1:0]     push_byte_i,
  input  logic                  uart_tx_full_i,
  input  logic                  uart_tx_empty_i,
  input  logic                  uart_busy_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  tx_valid_o,
  output logic [BYTE_W-1:0]     tx_byte_o,
  output logic [1:0]            gate_mode_o,
  output logic [QCNT_W-1:0]     queue_count_o,
  output logic                  push_dropped_o
);

  cfg_t    cfg_q;
  item_t   in_item, back_item;
  result_t back_res, out_res;
  logic    in_empty, back_pop, res_full, res_push;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.guard_ticks <= GUARD_TICKS_RST;
      cfg_q.lead_byte   <= LEAD_BYTE_RST;
      cfg_q.follow_byte <= FOLLOW_BYTE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GUARD_TICKS: cfg_q.guard_ticks <= cfg_data_i[GUARD_W-1:0];
        CFG_LEAD_BYTE:   cfg_q.lead_byte   <= cfg_data_i[BYTE_W-1:0];
        CFG_FOLLOW_BYTE: cfg_q.follow_byte <= cfg_data_i[BYTE_W-1:0];
        default:         cfg_q             <= cfg_q;
      endcase
    end
  end

  // Front: classify and queue incoming beats
  always_comb begin
    in_item.is_tick    = cmd_i;
    in_item.push_byte  = push_byte_i;
    in_item.uart_full  = uart_tx_full_i;
    in_item.uart_empty = uart_tx_empty_i;
    in_item.uart_busy  = uart_busy_i;
  end

  stg_fifo #(.Width($bits(item_t))) u_in_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  (in_item),
    .full_o  (full),
    .pop_i   (back_pop),
    .data_o  (back_item),
    .empty_o (in_empty)
  );

  // Back: ring queue and reset pair gate
  stg_back #(.QueueDepth(QueueDepth)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i        (cfg_q),
    .item_valid_i (!in_empty),
    .item_i       (back_item),
    .item_pop_o   (back_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res)
  );

  stg_fifo #(.Width($bits(result_t))) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_res),
    .empty_o (empty)
  );

  assign tx_valid_o     = out_res.tx_valid;
  assign tx_byte_o      = out_res.tx_byte;
  assign gate_mode_o    = out_res.gate_mode;
  assign queue_count_o  = out_res.queue_count;
  assign push_dropped_o = out_res.push_dropped;

`ifndef SYNTHESIS
  a_hold_sends_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && gate_mode_o == MODE_HOLD) |-> !tx_valid_o)
    else $error("byte sent while guard hold is in force");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !tx_valid_o) |-> (tx_byte_o == '0))
    else $error("tx_byte nonzero without tx_valid");

  a_drop_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && push_dropped_o) |-> !tx_valid_o)
    else $error("dropped push also reports a sent byte");
`endif

endmodule

// ===== hdl/stg_fifo.sv =====
module stg_fifo import stg_pkg::*; #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d = do_push ? !wptr_q : wptr_q;
    rptr_d = do_pop ? !rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold payload slots
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/stg_back.sv =====
module stg_back import stg_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    item_valid_i,
  input  item_t   item_i,
  output logic    item_pop_o,
  input  logic    res_full_i,
  output logic    res_push_o,
  output result_t res_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  function automatic logic [PtrW-1:0] used_of(input logic [PtrW-1:0] w,
                                              input logic [PtrW-1:0] r);
    logic [PtrW:0] diff;
    diff = {1'b0, w} - {1'b0, r};
    if (w < r) begin
      diff = diff + (PtrW+1)'(QueueDepth);
    end
    return diff[PtrW-1:0];
  endfunction

  logic [BYTE_W-1:0]  ring_mem [QueueDepth];
  logic [BYTE_W-1:0]  head_q, next_q;
  logic [PtrW-1:0]    rd_q, rd_d, wr_q, wr_d;
  logic [PtrW-1:0]    ra0, ra1;
  logic [PtrW-1:0]    used_q, used_d;
  mode_e              mode_q, mode_d;
  logic [GUARD_W-1:0] gc_q, gc_d;
  logic               go, tick, push;
  logic               ring_full, drain_ok, pair_at_head, head_is_follow, gc_done;
  logic               run_drain, send_follow, send, wr_en;

  // Take one item when a result slot is free
  assign go         = item_valid_i && !res_full_i;
  assign item_pop_o = go;
  assign res_push_o = go;
  assign tick       = go && (item_i.is_tick == CMD_TICK);
  assign push       = go && (item_i.is_tick == CMD_PUSH);

  // Classify the queue head
  assign used_q         = used_of(wr_q, rd_q);
  assign ring_full      = used_q == PtrW'(QueueDepth - 1);
  assign drain_ok       = (used_q != '0) && !item_i.uart_full;
  assign head_is_follow = head_q == cfg_i.follow_byte;
  assign pair_at_head   = (head_q == cfg_i.lead_byte) && (used_q >= PtrW'(2))
                          && (next_q == cfg_i.follow_byte);
  assign gc_done        = gc_q[GUARD_W-1:1] == '0;

  // Next gate mode
  always_comb begin
    mode_d = mode_q;
    if (tick) begin
      unique case (mode_q)
        MODE_NORMAL: begin
          if (drain_ok && pair_at_head) mode_d = MODE_FOLLOW;
        end
        MODE_FOLLOW: begin
          if (drain_ok) begin
            if (head_is_follow)    mode_d = MODE_IDLE_WAIT;
            else if (pair_at_head) mode_d = MODE_FOLLOW;
            else                   mode_d = MODE_NORMAL;
          end
        end
        MODE_IDLE_WAIT: begin
          if (item_i.uart_empty && !item_i.uart_busy) mode_d = MODE_HOLD;
        end
        MODE_HOLD: begin
          if (gc_done) begin
            mode_d = (drain_ok && pair_at_head) ? MODE_FOLLOW : MODE_NORMAL;
          end
        end
        default: mode_d = MODE_NORMAL;
      endcase
    end
  end

  // Drain actions and guard counter
  always_comb begin
    run_drain   = 1'b0;
    send_follow = 1'b0;
    gc_d        = gc_q;
    if (tick) begin
      unique case (mode_q)
        MODE_NORMAL: run_drain = 1'b1;
        MODE_FOLLOW: begin
          if (drain_ok) begin
            if (head_is_follow) send_follow = 1'b1;
            else                run_drain   = 1'b1;
          end
        end
        MODE_IDLE_WAIT: begin
          if (item_i.uart_empty && !item_i.uart_busy) gc_d = cfg_i.guard_ticks;
        end
        MODE_HOLD: begin
          if (gc_done) begin
            gc_d      = '0;
            run_drain = 1'b1;
          end else begin
            gc_d = gc_q - GUARD_W'(1);
          end
        end
        default: run_drain = 1'b0;
      endcase
    end
  end

  // Advance pointers
  assign send   = send_follow || (run_drain && drain_ok);
  assign wr_en  = push && !ring_full;
  assign rd_d   = send ? ptr_next(rd_q) : rd_q;
  assign wr_d   = wr_en ? ptr_next(wr_q) : wr_q;
  assign used_d = used_of(wr_d, rd_d);
  assign ra0    = rd_d;
  assign ra1    = ptr_next(rd_d);

  // Build the result beat
  always_comb begin
    res_o.tx_valid     = send;
    res_o.tx_byte      = send ? head_q : '0;
    res_o.gate_mode    = mode_d;
    res_o.queue_count  = QCNT_W'(used_d);
    res_o.push_dropped = push && ring_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      mode_q <= MODE_NORMAL;
      gc_q   <= '0;
    end else begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      mode_q <= mode_d;
      gc_q   <= gc_d;
    end
  end

  // Ring memory: write the tail, prefetch head and next with write bypass
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_mem[wr_q] <= item_i.push_byte;
    end
    head_q <= (wr_en && (wr_q == ra0)) ? item_i.push_byte : ring_mem[ra0];
    next_q <= (wr_en && (wr_q == ra1)) ? item_i.push_byte : ring_mem[ra1];
  end

endmodule

// ===== test/serial_tx_reset_guard_gate_test.sv =====
`timescale 1ns / 1ps

module serial_tx_reset_guard_gate_test;
  import stg_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;
  localparam int unsigned LONG_HOLD   = 64;

  // Predicts the gate's result for every accepted beat and keeps the results still due
  class tx_gate_board;
    logic [BYTE_W-1:0]  ring [QUEUE_DEPTH];
    logic [QCNT_W-1:0]  rd_ptr;
    logic [QCNT_W-1:0]  wr_ptr;
    mode_e              mode;
    logic [GUARD_W-1:0] guard_cnt;
    logic [GUARD_W-1:0] guard_ticks;
    logic [BYTE_W-1:0]  lead;
    logic [BYTE_W-1:0]  follow;
    result_t            tx_due[$];
    int                 errors;

    function void clear();
      rd_ptr      = '0;
      wr_ptr      = '0;
      mode        = MODE_NORMAL;
      guard_cnt   = '0;
      guard_ticks = GUARD_TICKS_RST;
      lead        = LEAD_BYTE_RST;
      follow      = FOLLOW_BYTE_RST;
      errors      = 0;
      tx_due.delete();
    endfunction

    function logic [QCNT_W-1:0] fill_level();
      return wr_ptr - rd_ptr;
    endfunction

    function int pending();
      return tx_due.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_GUARD_TICKS: guard_ticks = val[GUARD_W-1:0];
        CFG_LEAD_BYTE:   lead        = val[BYTE_W-1:0];
        CFG_FOLLOW_BYTE: follow      = val[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Advance the gate by one accepted beat and queue the result it must produce
    function void note_item(item_t it);
      result_t          r;
      logic             drain;
      logic [QCNT_W-1:0] nx;
      r     = '0;
      drain = 1'b0;
      if (it.is_tick == CMD_PUSH) begin
        if (fill_level() == QCNT_W'(QUEUE_DEPTH - 1)) begin
          r.push_dropped = 1'b1;
        end else begin
          ring[wr_ptr] = it.push_byte;
          wr_ptr++;
        end
      end else begin
        case (mode)
          MODE_FOLLOW: begin
            if (fill_level() != 0 && !it.uart_full) begin
              if (ring[rd_ptr] == follow) begin
                r.tx_valid = 1'b1;
                r.tx_byte  = ring[rd_ptr];
                rd_ptr++;
                mode = MODE_IDLE_WAIT;
              end else begin
                // follow byte gone: fall back and drain on this tick
                mode  = MODE_NORMAL;
                drain = 1'b1;
              end
            end
          end
          MODE_IDLE_WAIT: begin
            if (it.uart_empty && !it.uart_busy) begin
              guard_cnt = guard_ticks;
              mode      = MODE_HOLD;
            end
          end
          MODE_HOLD: begin
            if (guard_cnt <= 1) begin
              guard_cnt = '0;
              mode      = MODE_NORMAL;
              drain     = 1'b1;
            end else begin
              guard_cnt--;
            end
          end
          default: drain = 1'b1;
        endcase
        if (drain && fill_level() != 0 && !it.uart_full) begin
          nx         = rd_ptr + 1'b1;
          r.tx_valid = 1'b1;
          r.tx_byte  = ring[rd_ptr];
          if (ring[rd_ptr] == lead && fill_level() >= 2 && ring[nx] == follow)
            mode = MODE_FOLLOW;
          rd_ptr = nx;
        end
      end
      r.gate_mode   = mode;
      r.queue_count = fill_level();
      tx_due.push_back(r);
    endfunction

    // Compare one popped beat with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (tx_due.size() == 0) begin
        report("result beat with nothing due");
        return;
      end
      want = tx_due.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report($sformatf("tx_valid got %0d want %0d", got.tx_valid, want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report($sformatf("tx_byte got %h want %h", got.tx_byte, want.tx_byte));
      if (got.gate_mode !== want.gate_mode)
        report($sformatf("gate_mode got %0d want %0d", got.gate_mode, want.gate_mode));
      if (got.queue_count !== want.queue_count)
        report($sformatf("queue_count got %0d want %0d", got.queue_count, want.queue_count));
      if (got.push_dropped !== want.push_dropped)
        report($sformatf("push_dropped got %0d want %0d", got.push_dropped,
                         want.push_dropped));
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  push;
  logic                  full;
  logic                  cmd_i;
  logic [BYTE_W-1:0]     push_byte_i;
  logic                  uart_tx_full_i;
  logic                  uart_tx_empty_i;
  logic                  uart_busy_i;
  logic                  empty;
  logic                  pop;
  logic                  tx_valid_o;
  logic [BYTE_W-1:0]     tx_byte_o;
  logic [1:0]            gate_mode_o;
  logic [QCNT_W-1:0]     queue_count_o;
  logic                  push_dropped_o;

  tx_gate_board sb;
  bit           tx_idle_on = 1'b1;
  bit           rx_idle_on = 1'b1;
  bit           rx_long_hold = 1'b0;
  int           quiet_cycles = 0;

  serial_tx_reset_guard_gate uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .push_byte_i    (push_byte_i),
    .uart_tx_full_i (uart_tx_full_i),
    .uart_tx_empty_i(uart_tx_empty_i),
    .uart_busy_i    (uart_busy_i),
    .empty          (empty),
    .pop            (pop),
    .tx_valid_o     (tx_valid_o),
    .tx_byte_o      (tx_byte_o),
    .gate_mode_o    (gate_mode_o),
    .queue_count_o  (queue_count_o),
    .push_dropped_o (push_dropped_o)
  );

  always #4 clk_i = ~clk_i;

  // Drop the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("serial_tx_reset_guard_gate_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: check each popped beat, stall in bursts or on a long hold
  initial begin : receiver
    int      rx_stall;
    result_t got;
    rx_stall = 0;
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.tx_valid     = tx_valid_o;
        got.tx_byte      = tx_byte_o;
        got.gate_mode    = mode_e'(gate_mode_o);
        got.queue_count  = queue_count_o;
        got.push_dropped = push_dropped_o;
        sb.check_result(got);
      end
      if (rx_long_hold) begin
        rx_long_hold = 1'b0;
        rx_stall     = LONG_HOLD;
      end
      if (rx_stall != 0) begin
        rx_stall--;
        pop <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        rx_stall = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one beat, hold it until accepted, then maybe idle for a burst
  task automatic send_item(item_t it);
    push            <= 1'b1;
    cmd_i           <= it.is_tick;
    push_byte_i     <= it.push_byte;
    uart_tx_full_i  <= it.uart_full;
    uart_tx_empty_i <= it.uart_empty;
    uart_busy_i     <= it.uart_busy;
    do @(posedge clk_i); while (full);
    sb.note_item(it);
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic push_one(logic [BYTE_W-1:0] b);
    item_t it;
    it            = '0;
    it.is_tick    = CMD_PUSH;
    it.push_byte  = b;
    it.uart_full  = 1'($urandom_range(0, 1));
    it.uart_empty = 1'($urandom_range(0, 1));
    it.uart_busy  = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  task automatic tick_one(logic uart_full, logic uart_empty, logic uart_busy);
    item_t it;
    it            = '0;
    it.is_tick    = CMD_TICK;
    it.push_byte  = BYTE_W'($urandom_range(0, 255));
    it.uart_full  = uart_full;
    it.uart_empty = uart_empty;
    it.uart_busy  = uart_busy;
    send_item(it);
  endtask

  // Stop offering and wait until every predicted result has been popped
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Tick with an idle UART until the gate is back to normal with nothing queued
  task automatic empty_ring();
    while (sb.mode != MODE_NORMAL || sb.fill_level() != 0) tick_one(1'b0, 1'b1, 1'b0);
  endtask

  // Mostly pushes of pair bytes and ticks, so pairs form and the gate cycles its modes
  task automatic random_item(bit lead_ok);
    logic [BYTE_W-1:0] b;
    int                sel;
    if ($urandom_range(0, 99) < 45) begin
      sel = $urandom_range(0, 3);
      if (sel == 0)      b = sb.lead;
      else if (sel == 1) b = sb.follow;
      else               b = BYTE_W'($urandom_range(0, 255));
      if (!lead_ok && b == sb.lead) b = ~sb.lead;
      push_one(b);
    end else begin
      tick_one($urandom_range(0, 3) == 0, $urandom_range(0, 2) != 0,
               $urandom_range(0, 2) == 0);
    end
  endtask

  task automatic run_phase(logic [GUARD_W-1:0] g, logic [BYTE_W-1:0] ld,
                           logic [BYTE_W-1:0] fl, int n, bit lead_ok);
    empty_ring();
    wait_drained();
    write_reg(CFG_GUARD_TICKS, CFG_DATA_W'(g));
    write_reg(CFG_LEAD_BYTE, CFG_DATA_W'(ld));
    write_reg(CFG_FOLLOW_BYTE, CFG_DATA_W'(fl));
    repeat (n) random_item(lead_ok);
  endtask

  initial begin : stimulus
    sb = new;
    sb.clear();
    rst_ni          = 1'b0;
    push            <= 1'b0;
    cmd_i           <= CMD_PUSH;
    push_byte_i     <= '0;
    uart_tx_full_i  <= 1'b0;
    uart_tx_empty_i <= 1'b1;
    uart_busy_i     <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_GUARD_TICKS;
    cfg_data_i      <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain drain, UART full, lead byte alone, the full pair sequence
    write_reg(CFG_GUARD_TICKS, CFG_DATA_W'(2));
    tick_one(1'b0, 1'b1, 1'b0);
    push_one(8'h00);
    push_one(8'hff);
    tick_one(1'b1, 1'b1, 1'b0);
    tick_one(1'b0, 1'b0, 1'b1);
    tick_one(1'b0, 1'b1, 1'b0);
    push_one(LEAD_BYTE_RST);
    tick_one(1'b0, 1'b1, 1'b0);
    push_one(LEAD_BYTE_RST);
    push_one(FOLLOW_BYTE_RST);
    push_one(8'h5a);
    tick_one(1'b0, 1'b1, 1'b0);
    tick_one(1'b1, 1'b1, 1'b0);
    tick_one(1'b0, 1'b1, 1'b0);
    tick_one(1'b0, 1'b0, 1'b0);
    tick_one(1'b0, 1'b1, 1'b1);
    push_one(8'h33);
    tick_one(1'b0, 1'b1, 1'b0);
    tick_one(1'b0, 1'b1, 1'b0);
    tick_one(1'b0, 1'b1, 1'b0);

    // Directed: follow byte changed while waiting for it, gate falls back and drains
    push_one(LEAD_BYTE_RST);
    push_one(FOLLOW_BYTE_RST);
    tick_one(1'b0, 1'b1, 1'b0);
    tick_one(1'b0, 1'b1, 1'b0);
    wait_drained();
    write_reg(CFG_FOLLOW_BYTE, CFG_DATA_W'(8'h77));
    tick_one(1'b0, 1'b1, 1'b0);

    // Random phases over the register extremes; hold the result side off once
    rx_long_hold = 1'b1;
    run_phase(20'd0, 8'h00, 8'hff, 200, 1'b1);
    run_phase(20'd1, 8'hff, 8'h00, 200, 1'b1);
    run_phase(20'hfffff, 8'h3c, 8'hc3, 80, 1'b0);
    run_phase(GUARD_W'($urandom_range(2, 12)), 8'h5a, 8'h5a, 200, 1'b1);

    // Last stretch with both sides streaming
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_phase(GUARD_W'($urandom_range(0, 20)), BYTE_W'($urandom_range(0, 255)),
              BYTE_W'($urandom_range(0, 255)), 250, 1'b1);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("serial_tx_reset_guard_gate_test: clean");
    end else begin
      $display("serial_tx_reset_guard_gate_test: errors");
    end
    $finish;
  end

endmodule
